// ===== hdl/obd_pkg.sv =====
`default_nettype none

package obd_pkg;

  localparam int CompBits   = 32;
  localparam int ArcW       = 32;
  localparam int ByteW      = 8;
  localparam int GroupShift = 7;
  localparam int Arc1Base   = 40;
  localparam int Arc2Base   = 80;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    OP_ARC   = 2'd0,
    OP_SPLIT = 2'd1,
    OP_TRUNC = 2'd2,
    OP_OVF   = 2'd3
  } obd_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_OVF   = 2'd2
  } obd_status_e;

  typedef struct packed {
    obd_op_e               op;
    logic [CompBits-1:0]   value;
    logic                  last;
  } obd_entry_t;

  function automatic logic [ArcW-1:0] arc_of(input logic [CompBits-1:0] v);
    logic [CompBits+ArcW-1:0] ext;
    ext = {{ArcW{1'b0}}, v};
    return ext[ArcW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/obd_front.sv =====
`default_nettype none

module obd_front
  import obd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire logic [ByteW-1:0] content_byte_i,
  input  wire logic             content_last_i,
  output logic                  push_o,
  output obd_entry_t            entry_o
);

  logic [CompBits-1:0] acc_q, acc_d;
  logic                ovf_q, ovf_d;
  logic                first_q, first_d;

  logic                accept;
  logic                cont;
  logic                ovf_now;
  logic [CompBits-1:0] value;

  always_comb begin
    accept  = in_valid_i & ~in_stall_i;
    cont    = content_byte_i[ByteW-1];
    ovf_now = ovf_q | (|acc_q[CompBits-1 -: GroupShift]);
    value   = {acc_q[CompBits-GroupShift-1:0], content_byte_i[GroupShift-1:0]};

    push_o        = accept & (~cont | content_last_i);
    entry_o.value = value;
    entry_o.last  = content_last_i;
    if (cont) begin
      entry_o.op = OP_TRUNC;
    end else if (ovf_now) begin
      entry_o.op = OP_OVF;
    end else if (first_q) begin
      entry_o.op = OP_SPLIT;
    end else begin
      entry_o.op = OP_ARC;
    end

    acc_d   = acc_q;
    ovf_d   = ovf_q;
    first_d = first_q;
    if (accept) begin
      if (cont && !content_last_i) begin
        acc_d = value;
        ovf_d = ovf_now;
      end else begin
        acc_d   = '0;
        ovf_d   = 1'b0;
        first_d = content_last_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      first_q <= 1'b1;
    end else begin
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      first_q <= first_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/obd_fifo.sv =====
`default_nettype none

module obd_fifo
  import obd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire obd_entry_t entry_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output obd_entry_t      entry_o,
  output logic            empty_o
);

  obd_entry_t entries_q [QDepth];

  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    full_o  = (count_q == QCntW'(QDepth));
    empty_o = (count_q == '0);
    entry_o = entries_q[rd_ptr_q];
    do_push = push_i & ~full_o;
    do_pop  = pop_i & ~empty_o;

    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/obd_back.sv =====
`default_nettype none

module obd_back
  import obd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire obd_entry_t      entry_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic [ArcW-1:0]      arc_value_o,
  output logic                 run_end_o,
  output logic                 oid_end_o,
  output logic [1:0]           status_o
);

  logic            valid_q, valid_d;
  logic            phase_q, phase_d;
  logic [ArcW-1:0] arc_q, arc_d;
  logic            run_q, run_d;
  logic            oid_q, oid_d;
  obd_status_e     status_q, status_d;

  logic                load;
  logic                lt1;
  logic                lt2;
  logic [1:0]          top;
  logic [CompBits-1:0] rest;

  always_comb begin
    load = ~valid_q | ~out_stall_i;
    lt1  = entry_i.value < CompBits'(Arc1Base);
    lt2  = entry_i.value < CompBits'(Arc2Base);
    if (lt1) begin
      top  = 2'd0;
      rest = entry_i.value;
    end else if (lt2) begin
      top  = 2'd1;
      rest = entry_i.value - CompBits'(Arc1Base);
    end else begin
      top  = 2'd2;
      rest = entry_i.value - CompBits'(Arc2Base);
    end

    valid_d  = valid_q;
    phase_d  = phase_q;
    arc_d    = arc_q;
    run_d    = run_q;
    oid_d    = oid_q;
    status_d = status_q;
    pop_o    = 1'b0;

    if (load) begin
      valid_d = ~empty_i;
      if (!empty_i) begin
        pop_o    = 1'b1;
        phase_d  = 1'b0;
        run_d    = 1'b1;
        oid_d    = entry_i.last;
        status_d = ST_OK;
        unique case (entry_i.op)
          OP_TRUNC: begin
            arc_d    = '0;
            status_d = ST_TRUNC;
          end
          OP_OVF: begin
            arc_d    = '0;
            status_d = ST_OVF;
          end
          OP_SPLIT: begin
            if (!phase_q) begin
              arc_d   = {{(ArcW-2){1'b0}}, top};
              run_d   = 1'b0;
              oid_d   = 1'b0;
              phase_d = 1'b1;
              pop_o   = 1'b0;
            end else begin
              arc_d = arc_of(rest);
            end
          end
          OP_ARC: begin
            arc_d = arc_of(entry_i.value);
          end
          default: begin
            arc_d = '0;
          end
        endcase
      end
    end

    out_valid_o = valid_q;
    arc_value_o = arc_q;
    run_end_o   = run_q;
    oid_end_o   = oid_q;
    status_o    = status_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    arc_q    <= arc_d;
    run_q    <= run_d;
    oid_q    <= oid_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire

// ===== hdl/oid_ber_decoder_unit.sv =====
// object identifier decoder for BER content octets
// input channel: one content octet per item on content_byte_i, with
// content_last_i set on the final octet of an identifier; accepted when
// in_valid_i is high and in_stall_o is low
// output channel: one component per item (arc_value_o, run_end_o,
// oid_end_o, status_o); taken when out_valid_o is high and out_stall_i low
// a completing octet is first written into the queue and then loaded into
// the output register before its first result shows
// throughput: one octet per cycle while in_stall_o is low; the first subidentifier of an
// identifier gives two results, so the output register limits the rate to
// one result per cycle and the four-entry queue absorbs the extra one
// continuation octets give no result but still wait while the queue is full
// when the receiver stalls, the output holds and the queue fills; once it
// is full in_stall_o rises until an entry drains
// reset clears the accumulator, overflow flag, queue and output valid, and
// the next subidentifier is taken as the first of a new identifier
`default_nettype none

module oid_ber_decoder_unit
  import obd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] content_byte_i,
  input  wire logic             content_last_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [ArcW-1:0]       arc_value_o,
  output logic                  run_end_o,
  output logic                  oid_end_o,
  output logic [1:0]            status_o
);

  logic       push;
  obd_entry_t push_entry;
  logic       full;
  logic       pop;
  obd_entry_t head_entry;
  logic       empty;

  assign in_stall_o = full;

  obd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (full),
    .content_byte_i (content_byte_i),
    .content_last_i (content_last_i),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  obd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (empty)
  );

  obd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .arc_value_o (arc_value_o),
    .run_end_o   (run_end_o),
    .oid_end_o   (oid_end_o),
    .status_o    (status_o)
  );

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (arc_value_o == '0))
    else $error("error item with nonzero arc");

  a_err_ends_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> run_end_o)
    else $error("error item not closing its run");

  a_oid_end_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && oid_end_o) |-> run_end_o)
    else $error("identifier end without run end");

  a_trunc_ends_oid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_TRUNC) |-> oid_end_o)
    else $error("truncation not closing identifier");

endmodule

`default_nettype wire

// ===== dv/oid_ber_decoder_unit_tb.sv =====
`timescale 1ns / 100ps

import obd_pkg::*;

typedef struct {
  logic [ArcW-1:0] arc;
  logic            run_end;
  logic            oid_end;
  obd_status_e     status;
} arc_rec_t;

class oid_result_board;
  arc_rec_t            arcs_due[$];
  logic [CompBits-1:0] group_acc;
  logic                group_ovf;
  logic                first_due;
  int                  mismatches;

  function new();
    mismatches = 0;
    start_oid();
  endfunction

  function void start_oid();
    group_acc = '0;
    group_ovf = 1'b0;
    first_due = 1'b1;
  endfunction

  function void add_arc(logic [ArcW-1:0] arc, logic run_end, logic oid_end,
                        obd_status_e status);
    arc_rec_t rec;
    rec.arc     = arc;
    rec.run_end = run_end;
    rec.oid_end = oid_end;
    rec.status  = status;
    arcs_due = {arcs_due, rec};
  endfunction

  function void note_octet(logic [ByteW-1:0] octet, logic last);
    logic [CompBits-1:0] sub_val;
    if ((group_acc >> (CompBits - GroupShift)) != 0) group_ovf = 1'b1;
    sub_val = (group_acc << GroupShift) | CompBits'(octet[6:0]);
    if (octet[7]) begin
      if (last) begin
        add_arc('0, 1'b1, 1'b1, ST_TRUNC);
        start_oid();
      end else begin
        group_acc = sub_val;
      end
    end else begin
      if (group_ovf) begin
        add_arc('0, 1'b1, last, ST_OVF);
      end else if (first_due) begin
        if (sub_val < Arc1Base) begin
          add_arc(ArcW'(0), 1'b0, 1'b0, ST_OK);
          add_arc(ArcW'(sub_val), 1'b1, last, ST_OK);
        end else if (sub_val < Arc2Base) begin
          add_arc(ArcW'(1), 1'b0, 1'b0, ST_OK);
          add_arc(ArcW'(sub_val - Arc1Base), 1'b1, last, ST_OK);
        end else begin
          add_arc(ArcW'(2), 1'b0, 1'b0, ST_OK);
          add_arc(ArcW'(sub_val - Arc2Base), 1'b1, last, ST_OK);
        end
      end else begin
        add_arc(ArcW'(sub_val), 1'b1, last, ST_OK);
      end
      group_acc = '0;
      group_ovf = 1'b0;
      first_due = 1'b0;
      if (last) start_oid();
    end
  endfunction

  function void check_arc(logic [ArcW-1:0] arc, logic run_end, logic oid_end,
                          logic [1:0] status);
    arc_rec_t rec;
    if (arcs_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: arc=%h run_end=%b oid_end=%b status=%0d",
                 arc, run_end, oid_end, status);
    end else begin
      rec = arcs_due.pop_front();
      if (arc !== rec.arc || run_end !== rec.run_end || oid_end !== rec.oid_end ||
          status !== rec.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp arc=%h run_end=%b oid_end=%b status=%0d, %s",
                   rec.arc, rec.run_end, rec.oid_end, rec.status,
                   $sformatf("got arc=%h run_end=%b oid_end=%b status=%0d",
                             arc, run_end, oid_end, status));
      end
    end
  endfunction

  function int pending();
    return arcs_due.size();
  endfunction

  function bit failed();
    return mismatches != 0 || arcs_due.size() != 0;
  endfunction
endclass

module oid_ber_decoder_unit_tb;

  localparam int WatchLimit = 2000;
  localparam int HoldCycles = 300;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [ByteW-1:0] content_byte_i = '0;
  logic             content_last_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ArcW-1:0]  arc_value_o;
  logic             run_end_o;
  logic             oid_end_o;
  logic [1:0]       status_o;

  oid_result_board board = new();

  int   in_idle_pct = 0;
  int   stall_pct = 0;
  int   octets_sent = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;

  oid_ber_decoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .content_byte_i (content_byte_i),
    .content_last_i (content_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .arc_value_o    (arc_value_o),
    .run_end_o      (run_end_o),
    .oid_end_o      (oid_end_o),
    .status_o       (status_o)
  );

  always #1 clk_i = ~clk_i;

  // receiver side, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_seen != hold_toggle) begin
      hold_seen   <= hold_toggle;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (in_valid_i && !in_stall_o) board.note_octet(content_byte_i, content_last_i);
      if (out_valid_o && !out_stall_i)
        board.check_arc(arc_value_o, run_end_o, oid_end_o, status_o);
      if (quiet_cycles >= WatchLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_octet(input logic [ByteW-1:0] octet, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    content_byte_i <= octet;
    content_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    octets_sent++;
  endtask

  // base-128 encoding, most significant group first
  task automatic send_subid(input logic [63:0] sub_val, input logic last, input int pad);
    int groups;
    groups = 1;
    while (groups < 10 && (sub_val >> (7 * groups)) != 0) groups++;
    repeat (pad) send_octet(8'h80, 1'b0);
    for (int i = groups - 1; i >= 0; i--)
      send_octet({i != 0, 7'(sub_val >> (7 * i))}, last && i == 0);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_subid();
    int          sel;
    logic [63:0] pick;
    sel = $urandom_range(99);
    if (sel < 30) begin
      pick = $urandom_range(127);
    end else if (sel < 45) begin
      case ($urandom_range(7))
        0: pick = 39;
        1: pick = 40;
        2: pick = 79;
        3: pick = 80;
        4: pick = 128;
        5: pick = 16383;
        6: pick = 64'hffff_ffff;
        default: pick = 64'h1_0000_0000;
      endcase
    end else if (sel < 88) begin
      pick = 64'($urandom) >> $urandom_range(31);
    end else begin
      pick = ({32'($urandom), 32'($urandom)} >> $urandom_range(20, 31)) &
             64'h1fff_ffff_ffff;
    end
    return pick;
  endfunction

  task automatic send_oid();
    int arcs;
    bit trunc;
    arcs  = $urandom_range(1, 5);
    trunc = ($urandom_range(99) < 8);
    for (int k = 0; k < arcs; k++) begin
      if (trunc && k == arcs - 1) begin
        repeat ($urandom_range(3)) send_octet({1'b1, 7'($urandom)}, 1'b0);
        send_octet({1'b1, 7'($urandom)}, 1'b1);
      end else begin
        send_subid(pick_subid(), k == arcs - 1,
                   ($urandom_range(99) < 10) ? $urandom_range(1, 2) : 0);
      end
    end
  endtask

  task automatic random_phase(input int idle, input int stall, input int count);
    int target;
    target      = octets_sent + count;
    in_idle_pct = idle;
    stall_pct  <= stall;
    while (octets_sent < target) begin
      if ($urandom_range(99) < 5) begin
        send_octet(8'($urandom), 1'($urandom));
      end else begin
        send_oid();
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first arc boundaries, one octet per identifier
    send_subid(0, 1'b1, 0);
    send_subid(39, 1'b1, 0);
    send_subid(40, 1'b1, 0);
    send_subid(79, 1'b1, 0);
    send_subid(80, 1'b1, 0);
    send_subid(127, 1'b1, 0);
    // widest values that still fit
    send_subid(64'hffff_ffff, 1'b0, 0);
    send_subid(64'hffff_ffff, 1'b1, 0);
    // truncated identifier
    send_octet(8'h81, 1'b1);
    // padded first arc, then overflow, then truncation
    send_subid(5, 1'b0, 1);
    send_subid(64'h1_0000_0000, 1'b0, 0);
    send_octet(8'hff, 1'b1);
    drain_results();

    // receiver holds off while the sender keeps going
    in_idle_pct = 0;
    stall_pct  <= 0;
    hold_toggle <= ~hold_toggle;
    repeat (24) send_subid($urandom_range(127), 1'b1, 0);
    drain_results();

    random_phase(0, 0, 145);
    random_phase(66, 0, 145);
    random_phase(0, 66, 145);
    random_phase(12, 12, 145);

    repeat (10) @(posedge clk_i);
    if (board.failed()) begin
      $display("Simulation FAILED");
    end else begin
      $display("Simulation PASSED");
    end
    $finish;
  end

endmodule

// ===== oid_ber_decoder_unit.f =====
hdl/obd_pkg.sv
hdl/obd_front.sv
hdl/obd_fifo.sv
hdl/obd_back.sv
hdl/oid_ber_decoder_unit.sv
dv/oid_ber_decoder_unit_tb.sv
